// ===== design/gtl_pkg.sv =====
// Shared types and constants for the grammar token lexer.
package gtl_pkg;

	localparam int WORD_LEN_MAX_DEF = 255;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [3:0] K_ID    = 4'd0;
	localparam logic [3:0] K_EPS   = 4'd1;
	localparam logic [3:0] K_RULES = 4'd2;
	localparam logic [3:0] K_TERM  = 4'd3;
	localparam logic [3:0] K_ARROW = 4'd4;
	localparam logic [3:0] K_COMMA = 4'd5;
	localparam logic [3:0] K_LCURL = 4'd6;
	localparam logic [3:0] K_RCURL = 4'd7;
	localparam logic [3:0] K_BAR   = 4'd8;
	localparam logic [3:0] K_SEMI  = 4'd9;
	localparam logic [3:0] K_EOF   = 4'd10;
	localparam logic [3:0] K_ERR   = 4'd11;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] line;
		logic [7:0]  len;
		logic [7:0]  chr;
	} token_t;

	// one queue entry: the tokens caused by one input transaction
	typedef struct packed {
		logic   two;
		token_t t0;
		token_t t1;
	} tok_pair_t;

endpackage

// ===== design/gtl_front.sv =====
// Front end: classifies each character, keeps lexer state, builds token pairs.
module gtl_front #(
	parameter int WORD_LEN_MAX = gtl_pkg::WORD_LEN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              in_acc,
	input  logic [7:0]        char_code,
	input  logic              end_mark,
	output logic              push,
	output gtl_pkg::tok_pair_t entry
);
	import gtl_pkg::*;

	localparam int WLEN_W = $clog2(WORD_LEN_MAX + 1);
	localparam logic [55:0] EPS_TXT   = "EPSILON";
	localparam logic [39:0] RULES_TXT = "Rules";
	localparam logic [71:0] TERM_TXT  = "Terminals";

	logic              in_word_q, in_word_n;
	logic [WLEN_W-1:0] wlen_q, wlen_n;
	logic [15:0]       wline_q, wline_n;
	logic [2:0]        alive_q, alive_n;
	logic              dash_q, dash_n;
	logic [15:0]       line_q, line_n;

	logic              alnum, gt;
	logic [WLEN_W+7:0] wext;
	token_t            word_tok, pre_tok, sec_tok, pc_tok;
	logic              pre_v, sec_v, pc_en, pc_emit, pc_nl, pc_dash, pc_start, add;
	logic [WLEN_W-1:0] pos;
	logic [2:0]        base_alive, hit;
	logic [3:0]        p;

	always_comb begin
		alnum = (char_code >= "a" && char_code <= "z") ||
			(char_code >= "A" && char_code <= "Z") ||
			(char_code >= "0" && char_code <= "9");
		gt = (char_code == ">");

		wext = {8'd0, wlen_q};
		word_tok.kind = K_ID;
		if (alive_q[0] && wlen_q == WLEN_W'(7))
			word_tok.kind = K_EPS;
		if (alive_q[1] && wlen_q == WLEN_W'(5))
			word_tok.kind = K_RULES;
		if (alive_q[2] && wlen_q == WLEN_W'(9))
			word_tok.kind = K_TERM;
		word_tok.line = wline_q;
		word_tok.len  = (wext > (WLEN_W+8)'(255)) ? 8'hFF : wext[7:0];
		word_tok.chr  = 8'd0;

		if (dash_q) begin
			pre_tok = '{kind: K_ERR, line: line_q, len: 8'd0, chr: "-"};
			pre_v   = end_mark || !gt;
		end else begin
			pre_tok = word_tok;
			pre_v   = in_word_q && (end_mark || !alnum);
		end

		pc_en    = !end_mark && !(dash_q && gt) && !(in_word_q && alnum);
		pc_emit  = 1'b0;
		pc_nl    = 1'b0;
		pc_dash  = 1'b0;
		pc_start = 1'b0;
		pc_tok   = '{kind: K_ERR, line: line_q, len: 8'd0, chr: char_code};
		case (char_code)
			" ": ;
			8'd10, 8'd0: pc_nl = 1'b1;
			"-": pc_dash = 1'b1;
			",": begin pc_emit = 1'b1; pc_tok.kind = K_COMMA; end
			"{": begin pc_emit = 1'b1; pc_tok.kind = K_LCURL; end
			"}": begin pc_emit = 1'b1; pc_tok.kind = K_RCURL; end
			"|": begin pc_emit = 1'b1; pc_tok.kind = K_BAR; end
			";": begin pc_emit = 1'b1; pc_tok.kind = K_SEMI; end
			default: begin
				if (alnum)
					pc_start = 1'b1;
				else
					pc_emit = 1'b1;
			end
		endcase

		sec_v   = 1'b0;
		sec_tok = pc_tok;
		if (end_mark) begin
			sec_v   = 1'b1;
			sec_tok = '{kind: K_EOF, line: line_q, len: 8'd0, chr: 8'd0};
		end else if (dash_q && gt) begin
			sec_v   = 1'b1;
			sec_tok = '{kind: K_ARROW, line: line_q, len: 8'd0, chr: 8'd0};
		end else if (pc_en && pc_emit) begin
			sec_v = 1'b1;
		end

		push = in_acc && (pre_v || sec_v);
		entry.two = pre_v && sec_v;
		entry.t0  = pre_v ? pre_tok : sec_tok;
		entry.t1  = sec_tok;

		// keyword tracking for the character being appended
		add        = (!end_mark && in_word_q && alnum) || (pc_en && pc_start);
		pos        = (pc_en && pc_start) ? '0 : wlen_q;
		base_alive = (pc_en && pc_start) ? 3'b111 : alive_q;
		p          = pos[3:0];
		hit[0] = (pos < WLEN_W'(7)) ? (char_code == EPS_TXT[8*(6-int'(p)) +: 8]) : 1'b0;
		hit[1] = (pos < WLEN_W'(5)) ? (char_code == RULES_TXT[8*(4-int'(p)) +: 8]) : 1'b0;
		hit[2] = (pos < WLEN_W'(9)) ? (char_code == TERM_TXT[8*(8-int'(p)) +: 8]) : 1'b0;

		in_word_n = in_word_q;
		wlen_n    = wlen_q;
		wline_n   = wline_q;
		alive_n   = alive_q;
		dash_n    = dash_q;
		line_n    = line_q;
		if (end_mark) begin
			in_word_n = 1'b0;
			wlen_n    = '0;
			alive_n   = 3'b000;
			dash_n    = 1'b0;
		end else begin
			dash_n = 1'b0;
			if (in_word_q && !alnum) begin
				in_word_n = 1'b0;
				wlen_n    = '0;
				alive_n   = 3'b000;
			end
			if (pc_en && pc_nl && line_q != 16'hFFFF)
				line_n = line_q + 16'd1;
			if (pc_en && pc_dash)
				dash_n = 1'b1;
			if (pc_en && pc_start) begin
				in_word_n = 1'b1;
				wline_n   = line_q;
			end
			if (add) begin
				alive_n = base_alive & hit;
				wlen_n  = (pos < WLEN_W'(WORD_LEN_MAX)) ? pos + WLEN_W'(1) : pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			wlen_q    <= '0;
			wline_q   <= 16'd0;
			alive_q   <= 3'b000;
			dash_q    <= 1'b0;
			line_q    <= 16'd1;
		end else if (cfg_we) begin
			line_q <= cfg_data;
		end else if (in_acc) begin
			in_word_q <= in_word_n;
			wlen_q    <= wlen_n;
			wline_q   <= wline_n;
			alive_q   <= alive_n;
			dash_q    <= dash_n;
			line_q    <= line_n;
		end
	end

endmodule

// ===== design/gtl_queue.sv =====
// Short queue of token pairs between front end and back end.
module gtl_queue #(
	parameter int DEPTH = gtl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gtl_pkg::tok_pair_t wr_entry,
	input  logic               pop,
	output gtl_pkg::tok_pair_t head,
	output logic               full,
	output logic               empty
);
	import gtl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_pair_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== design/gtl_back.sv =====
// Back end: splits token pairs and drives the registered output stream.
module gtl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  gtl_pkg::tok_pair_t head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output gtl_pkg::token_t    out_tok,
	output logic               out_last
);
	import gtl_pkg::*;

	logic   phase_q;
	logic   valid_q;
	logic   last_q;
	token_t tok_q;
	logic   load;

	assign load      = (!valid_q || out_ready) && !empty;
	assign pop       = load && (phase_q || !head.two);
	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q && head.two;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= phase_q ? head.t1 : head.t0;
			last_q <= phase_q || !head.two;
		end
	end

endmodule

// ===== design/grammar_token_lexer_core.sv =====
// Top level of the grammar token lexer.
// Input stream: s_axis_tdata carries one character, s_axis_tuser marks end of input
// (the character is then ignored). One input transaction is taken per clock while
// s_axis_tready is high; a transaction gives zero, one or two tokens.
// Output stream: m_axis_tdata holds line, identifier length and character of a
// token, m_axis_tuser its kind, m_axis_tlast flags the last token of one input.
// From input to first token, the queue entry is written at the accepting edge and
// the output register is then loaded from it; the queue holds four
// token pairs.
// Output runs at one token per cycle while m_axis_tready is high; inputs that
// give two tokens send them one after the other, so the queue fills and
// s_axis_tready drops when the receiver stalls or many inputs produce pairs.
// With a free receiver and single tokens the block takes one character per cycle.
// cfg_we loads the line counter with cfg_data; write it only while idle.
// Reset clears the pending word and dash, empties the queue and sets the
// line counter to 1.
module grammar_token_lexer_core #(
	parameter int WORD_LEN_MAX = gtl_pkg::WORD_LEN_MAX_DEF,
	parameter int QUEUE_DEPTH  = gtl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code[7:0]
	input  logic        s_axis_tuser,  // end_mark
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // token_line[15:0], word_len[23:16], token_char[31:24]
	output logic [3:0]  m_axis_tuser,  // token_kind[3:0]
	output logic        m_axis_tlast   // last_of_run
);
	import gtl_pkg::*;

	logic      in_acc, push, pop, q_full, q_empty;
	tok_pair_t wr_entry, head;
	token_t    out_tok;

	assign s_axis_tready = !q_full;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	gtl_front #(.WORD_LEN_MAX(WORD_LEN_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_acc    (in_acc),
		.char_code (s_axis_tdata),
		.end_mark  (s_axis_tuser),
		.push      (push),
		.entry     (wr_entry)
	);

	gtl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	gtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tok   (out_tok),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_tok.chr, out_tok.len, out_tok.line};
	assign m_axis_tuser = out_tok.kind;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue pushed while full");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == K_EOF) |-> m_axis_tlast)
		else $error("end-of-file token not last of its transaction");

	a_len_only_words: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[23:16] != 8'd0) |->
		(m_axis_tuser == K_ID || m_axis_tuser == K_EPS ||
		 m_axis_tuser == K_RULES || m_axis_tuser == K_TERM))
		else $error("length on a non-identifier token");

endmodule
